// ===== rtl/ptq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptq_pkg;

    // Command codes
    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_REM = 2'd1;
    localparam logic [1:0] CMD_POP = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Request and result payloads
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] task_id;
        logic [15:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [15:0] out_task_id;
        logic [15:0] out_priority;
        logic [2:0]  status;
    } t_rsp;

    // One stored queue entry (stamp in the top word)
    typedef struct packed {
        logic [31:0] stamp;
        logic [15:0] pri;
        logic [15:0] id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Compare unit operating mode
    typedef enum logic {
        CMP_MATCH,
        CMP_ORDER
    } t_cmp_mode;

endpackage

`default_nettype wire

// ===== rtl/priority_task_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of (task id, priority) entries.
// Request channel: drive i_req and raise start; the request is taken at a
// clock edge where start is high and busy is low. busy then stays high
// until the request is finished.
// Result channel: o_valid pulses for one cycle with o_rsp; there is no
// back-pressure, the receiver must take it in that cycle.
// Commands: enqueue (duplicate id or full queue reported in status),
// remove by id, pop highest priority (oldest first among equals).
// Work, N = entries held: each request except the unused command scans
// the N stored entries one per cycle through a single read port of the
// entry RAM and one shared compare unit. Enqueue answers after the scan;
// remove hit or pop then reads the last entry and writes it to the freed slot.
// Misses, empty pop and an empty queue skip work and finish sooner.
// A new request can be taken in the cycle the result is shown.
// Reset (synchronous, active low) empties the queue and clears the arrival
// stamp; the entry RAM is not cleared and needs no clearing pass.
module priority_task_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire ptq_pkg::t_req i_req,
    output logic               busy,
    output logic               o_valid,
    output ptq_pkg::t_rsp      o_rsp
);
    import ptq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POST,
        S_MOVE_RD,
        S_MOVE_WR
    } t_state;

    t_state        r_state;
    logic [1:0]    r_cmd;
    logic [15:0]   r_id;
    logic [15:0]   r_pri;
    logic [CW-1:0] r_count;
    logic [31:0]   r_stamp;
    logic [CW-1:0] r_idx;
    logic          r_dv;
    logic [IW-1:0] r_didx;
    logic          r_found;
    logic [IW-1:0] r_kidx;
    t_entry        r_best;
    logic          r_valid;
    t_rsp          r_rsp;

    logic          w_issue;
    logic [CW-1:0] w_last_idx;
    logic          w_last_data;
    logic          w_enq_ok;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [IW-1:0] w_raddr;
    t_entry        w_rdata;
    t_cmp_mode     w_mode;
    logic          w_hit;

    // Scan and RAM port control
    assign w_issue     = (r_state == S_SCAN) && (r_idx < r_count);
    assign w_last_idx  = r_count - CW'(1);
    assign w_last_data = r_dv && (r_didx == w_last_idx[IW-1:0]);
    assign w_enq_ok    = (r_state == S_POST) && (r_cmd == CMD_ENQ) && !r_found
                         && (r_count != CAP_C);
    assign w_we        = w_enq_ok || (r_state == S_MOVE_WR);
    assign w_raddr     = (r_state == S_MOVE_RD) ? w_last_idx[IW-1:0] : r_idx[IW-1:0];
    assign w_mode      = (r_cmd == CMD_POP) ? CMP_ORDER : CMP_MATCH;

    always_comb begin
        if (r_state == S_MOVE_WR) begin
            w_waddr = r_kidx;
            w_wdata = w_rdata;
        end else begin
            w_waddr = r_count[IW-1:0];
            w_wdata = '{stamp: r_stamp, pri: r_pri, id: r_id};
        end
    end

    ptq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ptq_cmp u_cmp (
        .i_mode   (w_mode),
        .i_cand   (w_rdata),
        .i_best   (r_best),
        .i_key_id (r_id),
        .o_hit    (w_hit)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_stamp <= '0;
            r_valid <= 1'b0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_req.cmd;
                        r_id    <= i_req.task_id;
                        r_pri   <= i_req.priority_req;
                        r_idx   <= '0;
                        r_dv    <= 1'b0;
                        r_found <= 1'b0;
                        if (i_req.cmd == CMD_ENQ) begin
                            r_stamp <= r_stamp + 32'd1;
                        end
                        if (r_count == '0 || i_req.cmd == CMD_NOP) begin
                            r_state <= S_POST;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // one read issued and one entry compared per cycle
                    if (w_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    r_dv   <= w_issue;
                    r_didx <= r_idx[IW-1:0];
                    if (r_dv) begin
                        if (r_cmd == CMD_POP) begin
                            if (r_didx == '0 || w_hit) begin
                                r_best  <= w_rdata;
                                r_kidx  <= r_didx;
                                r_found <= 1'b1;
                            end
                        end else if (w_hit && !r_found) begin
                            r_best  <= w_rdata;
                            r_kidx  <= r_didx;
                            r_found <= 1'b1;
                        end
                    end
                    if (w_last_data) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    case (r_cmd)
                        CMD_ENQ: begin
                            r_rsp.out_task_id  <= r_id;
                            r_rsp.out_priority <= r_pri;
                            if (r_found) begin
                                r_rsp.status <= ST_DUP;
                            end else if (r_count == CAP_C) begin
                                r_rsp.status <= ST_FULL;
                            end else begin
                                r_rsp.status <= ST_OK;
                            end
                            if (w_enq_ok) begin
                                r_count <= r_count + CW'(1);
                            end
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        CMD_REM: begin
                            r_rsp.out_task_id <= r_id;
                            if (r_found) begin
                                r_rsp.out_priority <= r_best.pri;
                                r_rsp.status       <= ST_OK;
                                r_state            <= S_MOVE_RD;
                            end else begin
                                r_rsp.out_priority <= '0;
                                r_rsp.status       <= ST_NOTFOUND;
                                r_valid            <= 1'b1;
                                r_state            <= S_IDLE;
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                r_rsp.out_task_id  <= '0;
                                r_rsp.out_priority <= '0;
                                r_rsp.status       <= ST_EMPTY;
                                r_valid            <= 1'b1;
                                r_state            <= S_IDLE;
                            end else begin
                                r_rsp.out_task_id  <= r_best.id;
                                r_rsp.out_priority <= r_best.pri;
                                r_rsp.status       <= ST_OK;
                                r_state            <= S_MOVE_RD;
                            end
                        end
                        default: begin
                            r_rsp   <= '0;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_MOVE_RD: begin
                    // last entry is being read for the freed slot
                    r_state <= S_MOVE_WR;
                end
                S_MOVE_WR: begin
                    r_count <= w_last_idx;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ===== rtl/ptq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ptq_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptq_cmp (
    input  wire ptq_pkg::t_cmp_mode i_mode,
    input  wire ptq_pkg::t_entry    i_cand,
    input  wire ptq_pkg::t_entry    i_best,
    input  wire logic [15:0]        i_key_id,
    output logic                    o_hit
);
    import ptq_pkg::*;

    logic w_order;

    // Candidate leaves before best: higher priority, then older stamp, then lower id
    always_comb begin
        if (i_cand.pri != i_best.pri) begin
            w_order = i_cand.pri > i_best.pri;
        end else if (i_cand.stamp != i_best.stamp) begin
            w_order = i_cand.stamp < i_best.stamp;
        end else begin
            w_order = i_cand.id < i_best.id;
        end
    end

    // Shared result: id match for lookups, ordering for pop
    always_comb begin
        case (i_mode)
            CMP_MATCH: o_hit = (i_cand.id == i_key_id);
            CMP_ORDER: o_hit = w_order;
            default:   o_hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ptq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptq_port_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire ptq_pkg::t_req i_req,
    input wire logic          busy,
    input wire logic          o_valid,
    input wire ptq_pkg::t_rsp o_rsp
);
    import ptq_pkg::*;

    // Accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // A result comes exactly when busy drops
    a_valid_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $fell(busy))
        else $error("result strobe not aligned with end of busy");

    // Empty pop carries zero payload
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_EMPTY)
            |-> (o_rsp.out_task_id == '0 && o_rsp.out_priority == '0))
        else $error("empty result with nonzero payload");

    // Unused command returns all zero
    a_nop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.cmd == CMD_NOP) |=> ##1 (o_valid && o_rsp == '0))
        else $error("unused command gave nonzero result");

    // Reset leaves the block idle with no result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("block not idle after reset");

endmodule

bind priority_task_queue ptq_port_checker u_ptq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

`default_nettype wire
